// ----- rtl/tty_receive_queue_line_discipline_macros.svh -----
// ----------------------------------------------------------------------------
// tty_receive_queue_line_discipline_macros
// Assertion macros used by the checker file of the receive queue.
// ----------------------------------------------------------------------------
`ifndef TTY_RECEIVE_QUEUE_LINE_DISCIPLINE_MACROS_SVH
`define TTY_RECEIVE_QUEUE_LINE_DISCIPLINE_MACROS_SVH

// same-cycle implication, reset low disables
`define TRQL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("receive queue check failed");

// next-cycle implication, reset low disables
`define TRQL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("receive queue check failed");

`endif

// ----- rtl/trql_pkg.sv -----
// ----------------------------------------------------------------------------
// trql_pkg
// Constants and types of the terminal receive queue.
// ----------------------------------------------------------------------------
package trql_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [2:0] cause_t;
  typedef logic [2:0] cfg_idx_t;

  localparam int RING_DEPTH_DEF = 256;
  localparam int MAX_READ_DEF   = 64;

  localparam byte_t BYTE_CR   = 8'h0d;
  localparam byte_t BYTE_NL   = 8'h0a;
  localparam byte_t LOW_SEVEN = 8'h7f;

  localparam cause_t CAUSE_NONE  = 3'd0;
  localparam cause_t CAUSE_COUNT = 3'd1;
  localparam cause_t CAUSE_LINE  = 3'd2;
  localparam cause_t CAUSE_EOF   = 3'd3;
  localparam cause_t CAUSE_EMPTY = 3'd4;

  localparam cfg_idx_t CFG_CR_TO_NL   = 3'd0;
  localparam cfg_idx_t CFG_NL_TO_CR   = 3'd1;
  localparam cfg_idx_t CFG_IGNORE_CR  = 3'd2;
  localparam cfg_idx_t CFG_STRIP_BIT7 = 3'd3;
  localparam cfg_idx_t CFG_LINE_MODE  = 3'd4;
  localparam cfg_idx_t CFG_EOF_BYTE   = 3'd5;
  localparam cfg_idx_t CFG_EOL_BYTE   = 3'd6;
  localparam cfg_idx_t CFG_RAW_MIN    = 3'd7;

endpackage

// ----- rtl/tty_receive_queue_line_discipline.sv -----
// ----------------------------------------------------------------------------
// tty_receive_queue_line_discipline
// Receive side of a terminal line: input translation, receive ring, and
// canonical or raw reads from the ring.
// ----------------------------------------------------------------------------
// Usage:
//   in_* carries one word: a received byte (operation 0) or a read request
//   (operation 1). out_* returns one result word per receive, one word per
//   delivered byte and, for reads ending at end of file, on an empty ring or
//   with a zero count, one closing word. out_last marks the final word of an
//   item. cfg_* writes one register per cycle; the user must do so only
//   while the block is idle, which the block itself does not enforce.
//   A receive is accepted and its result word registered. A read scans the
//   ring, then replays the scanned bytes through the single ring read port,
//   whose data is registered; a zero count returns only its closing word.
//   in_stall is high from acceptance until the last result word is taken.
//   A stall on out_* holds the output register and the sequencer.
//   Reset clears the read pointer, occupancy, state and output valid, and
//   sets the configuration registers to their defaults; ring contents stay
//   undefined and take no clearing pass.
// ----------------------------------------------------------------------------
module tty_receive_queue_line_discipline #(
  parameter int RING_DEPTH = trql_pkg::RING_DEPTH_DEF,
  parameter int MAX_READ   = trql_pkg::MAX_READ_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_operation,
  input  trql_pkg::byte_t   in_rx_byte,
  input  logic [6:0]        in_read_count,
  output logic              out_valid,
  input  logic              out_stall,
  output trql_pkg::byte_t   out_data,
  output logic              out_has_data,
  output logic              out_last,
  output trql_pkg::cause_t  out_stop_cause,
  output logic              out_overwrote,
  output logic [8:0]        out_fill_level,
  input  logic              cfg_wr_en,
  input  trql_pkg::cfg_idx_t cfg_index,
  input  trql_pkg::byte_t   cfg_data
);
  import trql_pkg::*;

  localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int OCC_W = $clog2(RING_DEPTH + 1);
  localparam int CNT_W = $clog2(MAX_READ + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(RING_DEPTH - 1);
  localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(RING_DEPTH);
  localparam logic [OCC_W:0]   DEPTH_W  = (OCC_W+1)'(RING_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_ADDR,
    S_SCAN_DATA,
    S_EMIT_ADDR,
    S_EMIT_DATA,
    S_OUT
  } state_t;

  state_t           state_r;
  logic [PTR_W-1:0] rp_r;
  logic [OCC_W-1:0] occ_r;
  logic [PTR_W-1:0] ep_r;
  logic [CNT_W-1:0] limit_r;
  logic [CNT_W-1:0] got_r;
  logic [CNT_W-1:0] ndel_r;
  logic [CNT_W-1:0] ecnt_r;
  cause_t           cause_r;

  logic             cr2nl_r, nl2cr_r, igncr_r, strip_r, canon_r;
  byte_t            eof_r, eol_r, rawmin_r;

  logic             out_valid_r, out_has_r, out_last_r, out_ow_r;
  byte_t            out_data_r;
  cause_t           out_cause_r;

  byte_t            ring_mem [RING_DEPTH];
  byte_t            q_r;
  logic             rd_en;
  logic [PTR_W-1:0] rd_addr;
  logic             wr_en;
  logic [PTR_W-1:0] wr_addr;
  byte_t            wr_byte;

  logic             in_acc, out_acc;
  byte_t            rx_xlat;
  logic             rx_drop, ring_full;
  logic [OCC_W:0]   wr_sum;
  logic [PTR_W-1:0] rp_inc, ep_inc;
  logic [CNT_W-1:0] tgt, lim, got_inc, ecnt_inc;
  logic             is_eof, is_eol;
  logic [OCC_W+8:0] occ_wide;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid_r && !out_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    rx_xlat = in_rx_byte;
    if (in_rx_byte == BYTE_CR && cr2nl_r) begin
      rx_xlat = BYTE_NL;
    end else if (in_rx_byte == BYTE_NL && nl2cr_r) begin
      rx_xlat = BYTE_CR;
    end
    rx_drop = (rx_xlat == BYTE_CR) && igncr_r;
    if (strip_r) begin
      rx_xlat = rx_xlat & LOW_SEVEN;
    end
  end

  assign ring_full = (occ_r == FULL_OCC);
  assign wr_sum    = (OCC_W+1)'(rp_r) + (OCC_W+1)'(occ_r);
  assign rp_inc    = (rp_r == LAST_PTR) ? '0 : rp_r + 1'b1;
  assign ep_inc    = (ep_r == LAST_PTR) ? '0 : ep_r + 1'b1;

  always_comb begin
    logic [OCC_W:0] wrapped;
    wrapped = (wr_sum >= DEPTH_W) ? wr_sum - DEPTH_W : wr_sum;
    wr_addr = ring_full ? rp_r : wrapped[PTR_W-1:0];
  end

  assign wr_en   = in_acc && !in_operation && !rx_drop;
  assign wr_byte = rx_xlat;
  assign rd_en   = (state_r == S_SCAN_ADDR) || (state_r == S_EMIT_ADDR);
  assign rd_addr = (state_r == S_SCAN_ADDR) ? rp_r : ep_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= wr_byte;
    end
    if (rd_en) begin
      q_r <= ring_mem[rd_addr];
    end
  end

  assign tgt = (in_read_count > 7'(MAX_READ)) ? CNT_W'(MAX_READ)
                                              : in_read_count[CNT_W-1:0];
  assign lim = (!canon_r && rawmin_r != 8'd0 && rawmin_r < 8'(tgt))
               ? rawmin_r[CNT_W-1:0] : tgt;
  assign got_inc  = got_r + 1'b1;
  assign ecnt_inc = ecnt_r + 1'b1;
  assign is_eof   = canon_r && eof_r != 8'd0 && q_r == eof_r;
  assign is_eol   = canon_r && (q_r == BYTE_NL || (eol_r != 8'd0 && q_r == eol_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cr2nl_r  <= 1'b1;
      nl2cr_r  <= 1'b0;
      igncr_r  <= 1'b0;
      strip_r  <= 1'b0;
      canon_r  <= 1'b1;
      eof_r    <= 8'd4;
      eol_r    <= 8'd0;
      rawmin_r <= 8'd1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_CR_TO_NL:   cr2nl_r  <= cfg_data[0];
        CFG_NL_TO_CR:   nl2cr_r  <= cfg_data[0];
        CFG_IGNORE_CR:  igncr_r  <= cfg_data[0];
        CFG_STRIP_BIT7: strip_r  <= cfg_data[0];
        CFG_LINE_MODE:  canon_r  <= cfg_data[0];
        CFG_EOF_BYTE:   eof_r    <= cfg_data;
        CFG_EOL_BYTE:   eol_r    <= cfg_data;
        CFG_RAW_MIN:    rawmin_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rp_r        <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (!in_operation) begin
              if (!rx_drop) begin
                if (ring_full) begin
                  rp_r <= rp_inc;
                end else begin
                  occ_r <= occ_r + 1'b1;
                end
              end
              out_data_r  <= '0;
              out_has_r   <= 1'b0;
              out_last_r  <= 1'b1;
              out_cause_r <= CAUSE_NONE;
              out_ow_r    <= !rx_drop && ring_full;
              out_valid_r <= 1'b1;
              state_r     <= S_OUT;
            end else if (tgt == '0) begin
              out_data_r  <= '0;
              out_has_r   <= 1'b0;
              out_last_r  <= 1'b1;
              out_cause_r <= CAUSE_COUNT;
              out_ow_r    <= 1'b0;
              out_valid_r <= 1'b1;
              state_r     <= S_OUT;
            end else begin
              limit_r <= lim;
              got_r   <= '0;
              ep_r    <= rp_r;
              state_r <= S_SCAN_ADDR;
            end
          end
        end
        S_SCAN_ADDR: begin
          if (occ_r == '0) begin
            cause_r <= CAUSE_EMPTY;
            ndel_r  <= got_r;
            ecnt_r  <= '0;
            state_r <= S_EMIT_ADDR;
          end else begin
            state_r <= S_SCAN_DATA;
          end
        end
        S_SCAN_DATA: begin
          if (is_eof) begin
            if (got_r == '0) begin
              rp_r  <= rp_inc;
              occ_r <= occ_r - 1'b1;
            end
            cause_r <= CAUSE_EOF;
            ndel_r  <= got_r;
            ecnt_r  <= '0;
            state_r <= S_EMIT_ADDR;
          end else begin
            rp_r  <= rp_inc;
            occ_r <= occ_r - 1'b1;
            got_r <= got_inc;
            if (is_eol || got_inc >= limit_r) begin
              cause_r <= is_eol ? CAUSE_LINE : CAUSE_COUNT;
              ndel_r  <= got_inc;
              ecnt_r  <= '0;
              state_r <= S_EMIT_ADDR;
            end else begin
              state_r <= S_SCAN_ADDR;
            end
          end
        end
        S_EMIT_ADDR: begin
          if (ecnt_r == ndel_r) begin
            out_data_r  <= '0;
            out_has_r   <= 1'b0;
            out_last_r  <= 1'b1;
            out_cause_r <= cause_r;
            out_ow_r    <= 1'b0;
            out_valid_r <= 1'b1;
            state_r     <= S_OUT;
          end else begin
            state_r <= S_EMIT_DATA;
          end
        end
        S_EMIT_DATA: begin
          ecnt_r      <= ecnt_inc;
          ep_r        <= ep_inc;
          out_data_r  <= q_r;
          out_has_r   <= 1'b1;
          out_ow_r    <= 1'b0;
          out_valid_r <= 1'b1;
          if (ecnt_inc == ndel_r && (cause_r == CAUSE_LINE || cause_r == CAUSE_COUNT)) begin
            out_last_r  <= 1'b1;
            out_cause_r <= cause_r;
          end else begin
            out_last_r  <= 1'b0;
            out_cause_r <= CAUSE_NONE;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_acc) begin
            out_valid_r <= 1'b0;
            state_r     <= out_last_r ? S_IDLE : S_EMIT_ADDR;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign occ_wide       = (OCC_W+9)'(occ_r);
  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;
  assign out_has_data   = out_has_r;
  assign out_last       = out_last_r;
  assign out_stop_cause = out_cause_r;
  assign out_overwrote  = out_ow_r;
  assign out_fill_level = occ_wide[8:0];

endmodule

// ----- rtl/trql_checker.sv -----
// ----------------------------------------------------------------------------
// trql_checker
// Port-level checks of the terminal receive queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "tty_receive_queue_line_discipline_macros.svh"

module trql_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input trql_pkg::byte_t   out_data,
  input logic              out_has_data,
  input logic              out_last,
  input trql_pkg::cause_t  out_stop_cause
);
  import trql_pkg::*;

  `TRQL_ASSERT_NOW(a_empty_word_zero, clk, rst_n, out_valid && !out_has_data, out_data == 8'd0)
  `TRQL_ASSERT_NOW(a_empty_word_last, clk, rst_n, out_valid && !out_has_data, out_last)
  `TRQL_ASSERT_NOW(a_cause_on_last, clk, rst_n, out_valid && !out_last, out_stop_cause == CAUSE_NONE)
  `TRQL_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data) && $stable(out_last) && $stable(out_stop_cause))

endmodule

bind tty_receive_queue_line_discipline trql_checker u_trql_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_data       (out_data),
  .out_has_data   (out_has_data),
  .out_last       (out_last),
  .out_stop_cause (out_stop_cause)
);
